[sv/complex_arith_unit_assert.svh]
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define CAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// mode codes for the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

endpackage

[sv/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit
// complex add, subtract, multiply and divide on signed fixed point parts
// ----------------------------------------------------------------------------
//  channel   | ports        | handshake
//  request   | req_*        | start high while busy low moves one beat
//  response  | rsp_*        | rsp_valid marks one beat for one cycle
//
// one beat per cycle is taken; each beat passes through the divider line
// (2 product stages, one stage per quotient bit, rounding, saturation)
// every mode goes through the full line so results leave in order
// busy is always low: the receiver cannot stall and nothing backs up
// synchronous reset clears only the valid bits
module complex_arith_unit #(
   parameter int WIDTH     = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_mode,
   input  logic signed [WIDTH-1:0] req_a_real,
   input  logic signed [WIDTH-1:0] req_a_imag,
   input  logic signed [WIDTH-1:0] req_b_real,
   input  logic signed [WIDTH-1:0] req_b_imag,
   output logic                    rsp_valid,
   output logic signed [WIDTH-1:0] rsp_res_real,
   output logic signed [WIDTH-1:0] rsp_res_imag,
   output logic                    rsp_overflow,
   output logic                    rsp_div_zero
);
   `include "complex_arith_unit_assert.svh"

   localparam int NW  = 2 * WIDTH + 2;
   localparam int QW  = WIDTH + 2;

   assign busy = 1'b0;

   logic                 p_vld, p_dz;
   logic [1:0]           p_mode;
   logic signed [NW-1:0] p_re, p_im;
   logic [NW-1:0]        p_den;

   cau_prod #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS), .NW(NW)) u_prod (
      .clock(clock), .reset(reset), .in_vld(start && !busy), .in_mode(req_mode),
      .in_ar(req_a_real), .in_ai(req_a_imag), .in_br(req_b_real), .in_bi(req_b_imag),
      .out_vld(p_vld), .out_mode(p_mode), .out_re(p_re), .out_im(p_im),
      .out_den(p_den), .out_dz(p_dz)
   );

   // multiply products carry 2*FRAC_BITS fraction bits, and add/sub sums
   // arrive pre-shifted by FRAC_BITS; the divider scales by 2^FRAC_BITS, so
   // a den of 2^(2*FRAC_BITS) gives the rounded shift back to FRAC_BITS
   logic          is_div;
   logic [NW-1:0] den_sel, mag_re, mag_im;
   assign is_div  = 1'b1;
   assign den_sel = (p_mode == cau_pkg::MODE_DIV) ? (p_dz ? NW'(1) : p_den)
                                                  : (NW'(1) << (2 * FRAC_BITS));
   assign mag_re  = p_re[NW-1] ? NW'(-p_re) : p_re;
   assign mag_im  = p_im[NW-1] ? NW'(-p_im) : p_im;

   logic          d_vld_r, d_vld_i, d_neg_r, d_neg_i;
   logic [QW-1:0] d_mag_r, d_mag_i;

   cau_div #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS), .NW(NW)) u_div_re (
      .clock(clock), .reset(reset), .in_vld(p_vld), .in_div(is_div),
      .in_neg(p_re[NW-1]), .in_mag(p_dz ? '0 : mag_re), .in_den(den_sel),
      .out_vld(d_vld_r), .out_neg(d_neg_r), .out_mag(d_mag_r)
   );
   cau_div #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS), .NW(NW)) u_div_im (
      .clock(clock), .reset(reset), .in_vld(p_vld), .in_div(is_div),
      .in_neg(p_im[NW-1]), .in_mag(p_dz ? '0 : mag_im), .in_den(den_sel),
      .out_vld(d_vld_i), .out_neg(d_neg_i), .out_mag(d_mag_i)
   );

   // div-zero flag delay line alongside the divider
   localparam int DZD = NW + FRAC_BITS + 2;
   logic [DZD-1:0] dz_ff;
   always_ff @(posedge clock) begin
      dz_ff <= {dz_ff[DZD-2:0], p_dz};
   end

   // saturation stage
   localparam logic [QW-1:0] POS_LIM = (QW'(1) << (WIDTH - 1)) - QW'(1);
   localparam logic [QW-1:0] NEG_LIM = QW'(1) << (WIDTH - 1);
   logic          sat_r, sat_i;
   logic [QW-1:0] m_r, m_i;
   always_comb begin
      sat_r = d_neg_r ? (d_mag_r > NEG_LIM) : (d_mag_r > POS_LIM);
      sat_i = d_neg_i ? (d_mag_i > NEG_LIM) : (d_mag_i > POS_LIM);
      m_r   = sat_r ? (d_neg_r ? NEG_LIM : POS_LIM) : d_mag_r;
      m_i   = sat_i ? (d_neg_i ? NEG_LIM : POS_LIM) : d_mag_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= d_vld_r;
      end
      rsp_res_real <= d_neg_r ? WIDTH'(-m_r) : m_r[WIDTH-1:0];
      rsp_res_imag <= d_neg_i ? WIDTH'(-m_i) : m_i[WIDTH-1:0];
      rsp_overflow <= sat_r || sat_i;
      rsp_div_zero <= dz_ff[DZD-1];
   end

   // each divider keeps its own valid line; the two must agree
   `CAU_ASSERT_IMPL(a_lanes_agree, clock, reset, d_vld_r || d_vld_i, d_vld_r && d_vld_i,
      "divider lanes out of step")
   `CAU_ASSERT_NEXT(a_dz_zero, clock, reset, d_vld_r && dz_ff[DZD-1],
      rsp_res_real == '0 && rsp_res_imag == '0 && !rsp_overflow, "div by zero not zero")
   `CAU_ASSERT_IMPL(a_never_busy, clock, reset, start, !busy, "unit stalled")
   `CAU_ASSERT_NEXT(a_no_sat_flag, clock, reset, d_vld_r && !sat_r && !sat_i,
      !rsp_overflow, "overflow without saturation")
endmodule

[sv/cau_prod.sv]
// ----------------------------------------------------------------------------
// cau_prod
// front end: partial products and sums, two register stages
// ----------------------------------------------------------------------------
module cau_prod #(
   parameter int WIDTH     = 16,
   parameter int FRAC_BITS = 8,
   parameter int NW        = 2 * WIDTH + 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  logic [1:0]              in_mode,
   input  logic signed [WIDTH-1:0] in_ar,
   input  logic signed [WIDTH-1:0] in_ai,
   input  logic signed [WIDTH-1:0] in_br,
   input  logic signed [WIDTH-1:0] in_bi,
   output logic                    out_vld,
   output logic [1:0]              out_mode,
   output logic signed [NW-1:0]    out_re,
   output logic signed [NW-1:0]    out_im,
   output logic [NW-1:0]           out_den,
   output logic                    out_dz
);
   localparam int PW = 2 * WIDTH;

   // stage one: the four products and |b|^2 terms
   logic              vld1_ff;
   logic [1:0]        mode1_ff;
   logic signed [PW-1:0] rr_ff, ii_ff, ri_ff, ir_ff, bb_r_ff, bb_i_ff;
   logic signed [WIDTH:0] sr_ff, si_ff;
   logic              dz1_ff;
   logic signed [WIDTH:0] sr_in, si_in;

   always_comb begin
      if (in_mode == cau_pkg::MODE_SUB) begin
         sr_in = {in_ar[WIDTH-1], in_ar} - {in_br[WIDTH-1], in_br};
         si_in = {in_ai[WIDTH-1], in_ai} - {in_bi[WIDTH-1], in_bi};
      end else begin
         sr_in = {in_ar[WIDTH-1], in_ar} + {in_br[WIDTH-1], in_br};
         si_in = {in_ai[WIDTH-1], in_ai} + {in_bi[WIDTH-1], in_bi};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
      end
      mode1_ff <= in_mode;
      rr_ff    <= in_ar * in_br;
      ii_ff    <= in_ai * in_bi;
      ri_ff    <= in_ar * in_bi;
      ir_ff    <= in_ai * in_br;
      bb_r_ff  <= in_br * in_br;
      bb_i_ff  <= in_bi * in_bi;
      sr_ff    <= sr_in;
      si_ff    <= si_in;
      dz1_ff   <= (in_br == '0) && (in_bi == '0);
   end

   // stage two: combine products or sums per mode
   logic signed [NW-1:0] re_in, im_in;

   always_comb begin
      case (mode1_ff)
         cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
            re_in = NW'(sr_ff) <<< FRAC_BITS;
            im_in = NW'(si_ff) <<< FRAC_BITS;
         end
         cau_pkg::MODE_MUL: begin
            re_in = NW'(rr_ff) - NW'(ii_ff);
            im_in = NW'(ri_ff) + NW'(ir_ff);
         end
         default: begin
            re_in = NW'(rr_ff) + NW'(ii_ff);
            im_in = NW'(ir_ff) - NW'(ri_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld <= 1'b0;
      end else begin
         out_vld <= vld1_ff;
      end
      out_mode <= mode1_ff;
      out_re   <= re_in;
      out_im   <= im_in;
      out_den  <= NW'(unsigned'(bb_r_ff)) + NW'(unsigned'(bb_i_ff));
      out_dz   <= dz1_ff && (mode1_ff == cau_pkg::MODE_DIV);
   end
endmodule

[sv/cau_div.sv]
// ----------------------------------------------------------------------------
// cau_div
// pipelined restoring divider on magnitudes, one quotient bit per stage,
// with rounding of the last remainder; non-divide items ride through
// ----------------------------------------------------------------------------
module cau_div #(
   parameter int WIDTH     = 16,
   parameter int FRAC_BITS = 8,
   parameter int NW        = 2 * WIDTH + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  logic                 in_div,
   input  logic                 in_neg,
   input  logic [NW-1:0]        in_mag,
   input  logic [NW-1:0]        in_den,
   output logic                 out_vld,
   output logic                 out_neg,
   output logic [WIDTH+1:0]     out_mag
);
   // quotient width: value is clamped at 2^WIDTH, which fits in WIDTH+1 bits; QW is WIDTH+2
   localparam int QW    = WIDTH + 2;
   localparam int NBITS = NW + FRAC_BITS;
   localparam int ST    = NBITS;
   localparam logic [QW-1:0] CAP = QW'(1) << WIDTH;

   logic            vld_ff  [ST+1];
   logic            div_ff  [ST+1];
   logic            neg_ff  [ST+1];
   logic [NBITS-1:0] num_ff [ST+1];
   logic [NW:0]     rem_ff  [ST+1];
   logic [NW-1:0]   den_ff  [ST+1];
   logic [QW-1:0]   q_ff    [ST+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_vld;
      end
      div_ff[0] <= in_div;
      neg_ff[0] <= in_neg;
      num_ff[0] <= NBITS'(in_mag) << FRAC_BITS;
      rem_ff[0] <= '0;
      den_ff[0] <= in_den;
      q_ff[0]   <= '0;
   end

   for (genvar s = 0; s < ST; s++) begin : g_stage
      logic [NW:0]   r_sh;
      logic [NW+1:0] diff;
      logic          ge;
      logic [QW:0]   q_sh;
      logic [QW-1:0] q_in;
      always_comb begin
         r_sh = {rem_ff[s][NW-1:0], num_ff[s][NBITS-1]};
         diff = {1'b0, r_sh} - {2'b00, den_ff[s]};
         ge   = !diff[NW+1];
         q_sh = {q_ff[s], ge};
         q_in = (q_sh > {1'b0, CAP}) ? CAP : q_sh[QW-1:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_ff[s];
         end
         div_ff[s+1] <= div_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         num_ff[s+1] <= num_ff[s] << 1;
         rem_ff[s+1] <= div_ff[s] ? (ge ? diff[NW:0] : r_sh) : rem_ff[s];
         den_ff[s+1] <= den_ff[s];
         q_ff[s+1]   <= div_ff[s] ? q_in : q_ff[s];
      end
   end

   // rounding stage; pass-through items carry their value in pm_ff
   logic [NW+1:0]   r2;
   logic [QW:0]     qr;
   logic [QW-1:0]   mag_in;
   always_comb begin
      r2 = {rem_ff[ST], 1'b0};
      qr = {1'b0, q_ff[ST]} + ((r2 >= {2'b00, den_ff[ST]}) ? (QW+1)'(1) : '0);
      mag_in = (qr > {1'b0, CAP}) ? CAP : qr[QW-1:0];
   end

   // pass-through value travels in a separate register line
   logic [QW-1:0] pm_ff [ST+1];
   always_ff @(posedge clock) begin
      pm_ff[0] <= (in_mag > NW'(CAP)) ? CAP : in_mag[QW-1:0];
   end
   for (genvar s = 0; s < ST; s++) begin : g_pass
      always_ff @(posedge clock) begin
         pm_ff[s+1] <= pm_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld <= 1'b0;
      end else begin
         out_vld <= vld_ff[ST];
      end
      out_mag <= div_ff[ST] ? mag_in : pm_ff[ST];
      out_neg <= neg_ff[ST] && (div_ff[ST] ? (mag_in != '0) : (pm_ff[ST] != '0));
   end
endmodule
